// ===== rtl/core/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared sizes, sequencer states and the structs passed between the
// sequencer, the process table and the top level.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int VAL_W     = 16;
  localparam int PRIO_W    = 8;
  localparam int TICK_W    = 21;
  localparam int TOT_W     = 25;
  localparam int OIDX_W    = 4;
  localparam int IN_W      = 2 * VAL_W + PRIO_W;
  localparam int OUT_W     = OIDX_W + 2 * TICK_W + 2 * TOT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_APPLY,
    S_RADDR,
    S_RCALC,
    S_REMIT
  } seq_state_t;

  typedef struct packed {
    logic              ld_en;
    logic              upd_en;
    logic              comp_en;
    logic [IDX_W-1:0]  addr;
    logic [VAL_W-1:0]  arr;
    logic [VAL_W-1:0]  burst;
    logic [PRIO_W-1:0] prio;
    logic [VAL_W-1:0]  rem;
    logic [TICK_W-1:0] comp;
  } wr_t;

  typedef struct packed {
    logic [VAL_W-1:0]  arr;
    logic [VAL_W-1:0]  burst;
    logic [PRIO_W-1:0] prio;
    logic [VAL_W-1:0]  rem;
    logic [TICK_W-1:0] comp;
  } ent_t;

  typedef struct packed {
    logic              valid;
    logic [OIDX_W-1:0] idx;
    logic [TICK_W-1:0] wt;
    logic [TICK_W-1:0] tat;
    logic [TOT_W-1:0]  tw;
    logic [TOT_W-1:0]  tt;
    logic              last;
  } res_t;

endpackage

// ===== rtl/core/pps_store.sv =====
// ----------------------------------------------------------------------------
// Process table
// Holds arrival, burst, priority, remaining and completion per process,
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pps_store (
  input  logic                          clk,
  input  pps_pkg::wr_t                  wr,
  input  logic [pps_pkg::IDX_W-1:0]     rd_addr,
  output pps_pkg::ent_t                 rd_data
);
  import pps_pkg::*;

  logic [VAL_W-1:0]  arr_mem   [MAX_PROCS];
  logic [VAL_W-1:0]  burst_mem [MAX_PROCS];
  logic [PRIO_W-1:0] prio_mem  [MAX_PROCS];
  logic [VAL_W-1:0]  rem_mem   [MAX_PROCS];
  logic [TICK_W-1:0] comp_mem  [MAX_PROCS];
  ent_t              rd_r;

  always_ff @(posedge clk) begin
    if (wr.ld_en) begin
      arr_mem[wr.addr]   <= wr.arr;
      burst_mem[wr.addr] <= wr.burst;
      prio_mem[wr.addr]  <= wr.prio;
      rem_mem[wr.addr]   <= wr.rem;
    end else if (wr.upd_en) begin
      rem_mem[wr.addr] <= wr.rem;
    end
    if (wr.comp_en) begin
      comp_mem[wr.addr] <= wr.comp;
    end
  end

  always_ff @(posedge clk) begin
    rd_r.arr   <= arr_mem[rd_addr];
    rd_r.burst <= burst_mem[rd_addr];
    rd_r.prio  <= prio_mem[rd_addr];
    rd_r.rem   <= rem_mem[rd_addr];
    rd_r.comp  <= comp_mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule

// ===== rtl/core/pps_seq.sv =====
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Loads process records, runs the preemptive priority simulation by
// repeated scans of the process table, then reports each process.
// ----------------------------------------------------------------------------
module pps_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [pps_pkg::IN_W-1:0]   in_tdata,
  input  logic                       in_tlast,
  output pps_pkg::wr_t               wr,
  output logic [pps_pkg::IDX_W-1:0]  rd_addr,
  input  pps_pkg::ent_t              rd_data,
  output pps_pkg::res_t              res,
  input  logic                       res_ready
);
  import pps_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [CNT_W-1:0]  fin_r, fin_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              pick_v_r, pick_v_nxt;
  logic [IDX_W-1:0]  pick_idx_r, pick_idx_nxt;
  logic [PRIO_W-1:0] pick_prio_r, pick_prio_nxt;
  logic [VAL_W-1:0]  pick_rem_r, pick_rem_nxt;
  logic              next_v_r, next_v_nxt;
  logic [VAL_W-1:0]  next_arr_r, next_arr_nxt;
  logic [VAL_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  rep_r, rep_nxt;
  logic [TICK_W-1:0] tat_r, tat_nxt;
  logic [TICK_W-1:0] wt_r, wt_nxt;
  logic [TOT_W-1:0]  tw_r, tw_nxt;
  logic [TOT_W-1:0]  tt_r, tt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      loaded_r <= '0;
      fin_r    <= '0;
      tick_r   <= '0;
      issue_r  <= '0;
      rd_vld_r <= 1'b0;
      pick_v_r <= 1'b0;
      next_v_r <= 1'b0;
      rep_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      fin_r    <= fin_nxt;
      tick_r   <= tick_nxt;
      issue_r  <= issue_nxt;
      rd_vld_r <= rd_vld_nxt;
      pick_v_r <= pick_v_nxt;
      next_v_r <= next_v_nxt;
      rep_r    <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r   <= rd_last_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pick_idx_r  <= pick_idx_nxt;
    pick_prio_r <= pick_prio_nxt;
    pick_rem_r  <= pick_rem_nxt;
    next_arr_r  <= next_arr_nxt;
    run_r       <= run_nxt;
    tat_r       <= tat_nxt;
    wt_r        <= wt_nxt;
    tw_r        <= tw_nxt;
    tt_r        <= tt_nxt;
  end

  always_comb begin
    logic [VAL_W-1:0]  in_burst;
    logic [VAL_W-1:0]  bt;
    logic [TICK_W-1:0] diff;
    logic [VAL_W-1:0]  rem_new;
    logic [TICK_W-1:0] tick_new;
    logic              rep_last;

    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    fin_nxt       = fin_r;
    tick_nxt      = tick_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    pick_v_nxt    = pick_v_r;
    pick_idx_nxt  = pick_idx_r;
    pick_prio_nxt = pick_prio_r;
    pick_rem_nxt  = pick_rem_r;
    next_v_nxt    = next_v_r;
    next_arr_nxt  = next_arr_r;
    run_nxt       = run_r;
    rep_nxt       = rep_r;
    tat_nxt       = tat_r;
    wt_nxt        = wt_r;
    tw_nxt        = tw_r;
    tt_nxt        = tt_r;
    wr            = '0;
    rd_addr       = issue_r[IDX_W-1:0];
    res           = '0;
    in_tready     = 1'b0;

    in_burst = in_tdata[2*VAL_W-1:VAL_W];
    bt       = (in_burst == '0) ? VAL_W'(1) : in_burst;
    diff     = TICK_W'(next_arr_r) - tick_r;
    rem_new  = pick_rem_r - run_r;
    tick_new = tick_r + TICK_W'(run_r);
    rep_last = ((rep_r + CNT_W'(1)) == loaded_r);

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (loaded_r < CNT_W'(MAX_PROCS)) begin
            wr.ld_en   = 1'b1;
            wr.addr    = loaded_r[IDX_W-1:0];
            wr.arr     = in_tdata[VAL_W-1:0];
            wr.burst   = bt;
            wr.prio    = in_tdata[IN_W-1:2*VAL_W];
            wr.rem     = bt;
            loaded_nxt = loaded_r + CNT_W'(1);
          end
          if (in_tlast) begin
            state_nxt  = S_SCAN;
            tick_nxt   = '0;
            fin_nxt    = '0;
            issue_nxt  = '0;
            pick_v_nxt = 1'b0;
            next_v_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (issue_r < loaded_r) begin
          rd_addr     = issue_r[IDX_W-1:0];
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = issue_r[IDX_W-1:0];
          rd_last_nxt = ((issue_r + CNT_W'(1)) == loaded_r);
          issue_nxt   = issue_r + CNT_W'(1);
        end
        if (rd_vld_r && (rd_data.rem != '0)) begin
          if (TICK_W'(rd_data.arr) <= tick_r) begin
            if (!pick_v_r || (rd_data.prio < pick_prio_r)) begin
              pick_v_nxt    = 1'b1;
              pick_idx_nxt  = rd_idx_r;
              pick_prio_nxt = rd_data.prio;
              pick_rem_nxt  = rd_data.rem;
            end
          end else if (!next_v_r || (rd_data.arr < next_arr_r)) begin
            next_v_nxt   = 1'b1;
            next_arr_nxt = rd_data.arr;
          end
        end
        if (rd_vld_r && rd_last_r) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (!pick_v_r) begin
          tick_nxt   = TICK_W'(next_arr_r);
          state_nxt  = S_SCAN;
          issue_nxt  = '0;
          next_v_nxt = 1'b0;
        end else begin
          if (next_v_r && (diff < TICK_W'(pick_rem_r))) begin
            run_nxt = diff[VAL_W-1:0];
          end else begin
            run_nxt = pick_rem_r;
          end
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        wr.upd_en = 1'b1;
        wr.addr   = pick_idx_r;
        wr.rem    = rem_new;
        tick_nxt  = tick_new;
        if (rem_new == '0) begin
          wr.comp_en = 1'b1;
          wr.comp    = tick_new;
          fin_nxt    = fin_r + CNT_W'(1);
        end
        if ((rem_new == '0) && ((fin_r + CNT_W'(1)) == loaded_r)) begin
          state_nxt = S_RADDR;
          rep_nxt   = '0;
          tw_nxt    = '0;
          tt_nxt    = '0;
        end else begin
          state_nxt  = S_SCAN;
          issue_nxt  = '0;
          pick_v_nxt = 1'b0;
          next_v_nxt = 1'b0;
        end
      end
      S_RADDR: begin
        rd_addr   = rep_r[IDX_W-1:0];
        state_nxt = S_RCALC;
      end
      S_RCALC: begin
        tat_nxt   = rd_data.comp - TICK_W'(rd_data.arr);
        wt_nxt    = tat_nxt - TICK_W'(rd_data.burst);
        state_nxt = S_REMIT;
      end
      S_REMIT: begin
        res.valid = 1'b1;
        res.idx   = OIDX_W'(rep_r);
        res.wt    = wt_r;
        res.tat   = tat_r;
        res.last  = rep_last;
        if (rep_last) begin
          res.tw = tw_r + TOT_W'(wt_r);
          res.tt = tt_r + TOT_W'(tat_r);
        end
        if (res_ready) begin
          tw_nxt = tw_r + TOT_W'(wt_r);
          tt_nxt = tt_r + TOT_W'(tat_r);
          if (rep_last) begin
            state_nxt  = S_IDLE;
            loaded_nxt = '0;
          end else begin
            rep_nxt   = rep_r + CNT_W'(1);
            state_nxt = S_RADDR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_apply_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> (pick_v_r && (run_r != '0)))
    else $error("time slice applied without a runnable process");

  a_fin_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (fin_r <= loaded_r))
    else $error("more processes finished than were loaded");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == S_SCAN))
    else $error("table read outside a scan");

  a_report_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REMIT) |-> (rep_r < loaded_r))
    else $error("report index beyond the loaded processes");

endmodule

// ===== rtl/core/preemptive_priority_schedule.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Loads process records, simulates preemptive priority scheduling and
// reports waiting and turnaround times per process, with totals.
// ----------------------------------------------------------------------------
// Records are taken one per cycle until the transfer marked with tlast. The
// simulation then advances in steps from one arrival or completion to the
// next; each step scans all n loaded processes through the single registered
// read port of the process table, and a batch needs at most about 3n steps.
// Reporting passes each process through address, calculate and emit states,
// and waits in the emit state on any output stall. The input is not ready
// from the tlast transfer until the final result has gone into the output register.
module preemptive_priority_schedule (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // arrival_time[15:0], burst_time[31:16], priority_req[39:32]
  input  logic [pps_pkg::IN_W-1:0]    in_tdata,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // process_index[3:0], waiting_time[24:4], turnaround_time[45:25],
  // total_waiting[70:46], total_turnaround[95:71]
  output logic [pps_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast
);
  import pps_pkg::*;

  wr_t              wr;
  logic [IDX_W-1:0] rd_addr;
  ent_t             rd_data;
  res_t             res;
  logic             res_ready;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic             out_tlast_r;

  pps_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pps_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_tdata_r <= {res.tt, res.tw, res.tat, res.wt, res.idx};
      out_tlast_r <= res.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== test/preemptive_priority_schedule_tb.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Streams batches of process records into the scheduler and checks every
// reported waiting and turnaround time, and the batch totals, against a
// priority scheduling predictor that runs when the closing record is taken.
// ----------------------------------------------------------------------------
module preemptive_priority_schedule_tb;
  import pps_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int CALM_FROM    = 2000;
  localparam int CALM_TO      = 3500;

  typedef struct {
    logic [VAL_W-1:0]  arrival;
    logic [VAL_W-1:0]  burst;
    logic [PRIO_W-1:0] prio;
    logic              last;
  } proc_rec_t;

  typedef struct packed {
    logic [TOT_W-1:0]  turn_total;
    logic [TOT_W-1:0]  wait_total;
    logic [TICK_W-1:0] turnaround;
    logic [TICK_W-1:0] waiting;
    logic [OIDX_W-1:0] proc_idx;
  } timing_word_t;

  typedef struct {
    timing_word_t word;
    logic         is_last;
  } timing_rec_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;

  proc_rec_t         proc_q[$];
  proc_rec_t         in_cur;
  timing_rec_t       timing_q[$];

  logic [VAL_W-1:0]  tbl_arrival[MAX_PROCS];
  logic [VAL_W-1:0]  tbl_burst[MAX_PROCS];
  logic [PRIO_W-1:0] tbl_prio[MAX_PROCS];
  int                tbl_count  = 0;

  int                cyc        = 0;
  int                errors     = 0;
  int                hold_left  = 0;
  int                holds_done = 0;

  preemptive_priority_schedule uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic bit take_break();
    if (cyc >= CALM_FROM && cyc < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < 16;
  endfunction

  function automatic int unsigned pick_value(int unsigned near_max, int unsigned top);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 65) begin
      return $urandom_range(near_max);
    end else if (sel < 80) begin
      return $urandom_range(top);
    end else if (sel < 90) begin
      return 0;
    end
    return top;
  endfunction

  function automatic void add_proc(int unsigned at, int unsigned bt, int unsigned pr, bit last);
    proc_rec_t r;
    r.arrival = at[VAL_W-1:0];
    r.burst   = bt[VAL_W-1:0];
    r.prio    = pr[PRIO_W-1:0];
    r.last    = last;
    proc_q.push_back(r);
  endfunction

  // Stores one taken record; the closing record runs the schedule and queues
  // one timing per loaded process.
  function automatic void load_proc(proc_rec_t r);
    int unsigned left[MAX_PROCS];
    int unsigned done_at[MAX_PROCS];
    int unsigned now, next_arr, step, turn, waited, sum_wait, sum_turn;
    int          pick, finished, i;
    bit          have_next;
    timing_rec_t t;
    if (tbl_count < MAX_PROCS) begin
      tbl_arrival[tbl_count] = r.arrival;
      tbl_burst[tbl_count]   = (r.burst == '0) ? VAL_W'(1) : r.burst;
      tbl_prio[tbl_count]    = r.prio;
      tbl_count++;
    end
    if (!r.last) begin
      return;
    end
    for (i = 0; i < tbl_count; i++) begin
      left[i] = 32'(tbl_burst[i]);
    end
    now = 0;
    finished = 0;
    while (finished < tbl_count) begin
      pick = -1;
      have_next = 1'b0;
      next_arr = 0;
      for (i = 0; i < tbl_count; i++) begin
        if (left[i] != 0) begin
          if (tbl_arrival[i] <= now) begin
            if (pick < 0 || tbl_prio[i] < tbl_prio[pick]) begin
              pick = i;
            end
          end else if (!have_next || tbl_arrival[i] < next_arr) begin
            next_arr = 32'(tbl_arrival[i]);
            have_next = 1'b1;
          end
        end
      end
      if (pick < 0) begin
        now = next_arr;
      end else begin
        step = left[pick];
        if (have_next && next_arr - now < step) begin
          step = next_arr - now;
        end
        left[pick] -= step;
        now += step;
        if (left[pick] == 0) begin
          done_at[pick] = now;
          finished++;
        end
      end
    end
    sum_wait = 0;
    sum_turn = 0;
    for (i = 0; i < tbl_count; i++) begin
      turn = done_at[i] - tbl_arrival[i];
      waited = turn - tbl_burst[i];
      sum_wait += waited;
      sum_turn += turn;
      t.word.proc_idx   = i[OIDX_W-1:0];
      t.word.waiting    = waited[TICK_W-1:0];
      t.word.turnaround = turn[TICK_W-1:0];
      t.is_last         = (i == tbl_count - 1);
      t.word.wait_total = t.is_last ? sum_wait[TOT_W-1:0] : '0;
      t.word.turn_total = t.is_last ? sum_turn[TOT_W-1:0] : '0;
      timing_q.push_back(t);
    end
    tbl_count = 0;
  endfunction

  function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : drive
    bit hold;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        load_proc(in_cur);
      end
      hold = in_tvalid && !in_tready;
      if (!hold) begin
        if (proc_q.size() != 0 && !take_break()) begin
          in_cur = proc_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {in_cur.prio, in_cur.burst, in_cur.arrival};
          in_tlast  <= in_cur.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off stalls the output while a result waits, so records keep being offered but are not taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (out_tvalid && holds_done < 2 && cyc >= 800 + holds_done * 4000) begin
      out_tready <= 1'b0;
      hold_left  <= 300;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= !take_break();
    end
  end

  always @(posedge clk) begin : watch
    timing_rec_t  exp_r;
    timing_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = timing_word_t'(out_tdata);
      if (timing_q.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual index %0d",
                 $time, got.proc_idx);
        errors++;
      end else begin
        exp_r = timing_q.pop_front();
        check_field("process_index", 32'(exp_r.word.proc_idx), 32'(got.proc_idx));
        check_field("waiting_time", 32'(exp_r.word.waiting), 32'(got.waiting));
        check_field("turnaround_time", 32'(exp_r.word.turnaround), 32'(got.turnaround));
        check_field("total_waiting", 32'(exp_r.word.wait_total), 32'(got.wait_total));
        check_field("total_turnaround", 32'(exp_r.word.turn_total), 32'(got.turn_total));
        check_field("last_result", 32'(exp_r.is_last), 32'(out_tlast));
      end
    end
  end

  initial begin : run
    int sel, n, k, random_items;
    add_proc(0, 1, 0, 1'b1);
    add_proc(65535, 65535, 255, 1'b1);
    add_proc(10, 0, 7, 1'b0);
    add_proc(0, 20, 200, 1'b0);
    add_proc(5, 3, 7, 1'b0);
    add_proc(5, 4, 7, 1'b0);
    add_proc(2, 10, 0, 1'b1);
    for (k = 0; k < 18; k++) begin
      add_proc($urandom_range(30), $urandom_range(1, 9), $urandom_range(3), k == 17);
    end
    random_items = 0;
    while (random_items < 195) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        n = $urandom_range(17, 20);
      end else if (sel < 40) begin
        n = $urandom_range(1, 3);
      end else begin
        n = $urandom_range(4, 16);
      end
      for (k = 0; k < n; k++) begin
        add_proc(pick_value(40, 65535), pick_value(12, 65535), pick_value(3, 255), k == n - 1);
      end
      random_items += n;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (proc_q.size() != 0 || in_tvalid || timing_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("preemptive_priority_schedule_tb OK");
    end else begin
      $display("preemptive_priority_schedule_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("preemptive_priority_schedule_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pps_pkg.sv
rtl/core/pps_store.sv
rtl/core/pps_seq.sv
rtl/core/preemptive_priority_schedule.sv
test/preemptive_priority_schedule_tb.sv
